### rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared sizes, types and helpers for the four-level priority ring queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int CODE_BITS   = 8;
    localparam int LEVEL_COUNT = 4;
    localparam int LEVEL_W     = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SLOT_COUNT  = LEVEL_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(SLOT_COUNT);

    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [LEVEL_W-1:0]   t_level;
    typedef logic [ADDR_W-1:0]    t_addr;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic   write;
        logic   hit;
        t_level lvl;
        t_addr  addr;
        logic   dropped;
    } t_sched;

    function automatic t_ptr next_ptr(t_ptr p);
        return (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_addr slot_addr(t_level l, t_ptr p);
        return t_addr'(l) * t_addr'(QUEUE_DEPTH) + t_addr'(p);
    endfunction

endpackage

### rtl/prq_sched.sv
// ----------------------------------------------------------------------------
// prq_sched
// Per-level read/write pointers, strict priority pick and store address.
// ----------------------------------------------------------------------------
module prq_sched import prq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  logic   i_action,
    input  t_level i_level,
    output t_sched o_sched
);

    t_ptr r_rd [LEVEL_COUNT];
    t_ptr r_wr [LEVEL_COUNT];
    t_ptr n_rd [LEVEL_COUNT];
    t_ptr n_wr [LEVEL_COUNT];

    logic   w_push;
    logic   w_hit;
    t_level w_pop_lvl;
    logic   w_drop;
    t_ptr   w_wr_next;

    always_comb begin
        w_push    = (i_action == ACT_PUSH);
        w_hit     = 1'b0;
        w_pop_lvl = '0;
        for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
            if (r_rd[l] != r_wr[l]) begin
                w_hit     = 1'b1;
                w_pop_lvl = LEVEL_W'(l);
            end
        end
        w_wr_next = next_ptr(r_wr[i_level]);
        w_drop    = (r_rd[i_level] == w_wr_next);
    end

    always_comb begin
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            n_wr[l] = r_wr[l];
            n_rd[l] = r_rd[l];
            if (w_push) begin
                if (i_level == LEVEL_W'(l)) begin
                    n_wr[l] = w_wr_next;
                    if (w_drop) begin
                        n_rd[l] = next_ptr(r_rd[l]);
                    end
                end
            end else if (w_hit && (w_pop_lvl == LEVEL_W'(l))) begin
                n_rd[l] = next_ptr(r_rd[l]);
            end
        end
    end

    always_comb begin
        o_sched.write   = w_push;
        o_sched.hit     = !w_push && w_hit;
        o_sched.lvl     = w_push ? '0 : w_pop_lvl;
        o_sched.addr    = w_push ? slot_addr(i_level, r_wr[i_level])
                                 : slot_addr(w_pop_lvl, r_rd[w_pop_lvl]);
        o_sched.dropped = w_push && w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_rd[l] <= '0;
                r_wr[l] <= '0;
            end
        end else if (i_advance) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_rd[l] <= n_rd[l];
                r_wr[l] <= n_wr[l];
            end
        end
    end

endmodule

### rtl/four_level_priority_ring_queue.sv
// ----------------------------------------------------------------------------
// four_level_priority_ring_queue
// Four overwrite-oldest ring queues served in strict priority order.
// ----------------------------------------------------------------------------
// Each item is a push (store entry_code at the tail of the given level; when
// that level is full the oldest entry is discarded and dropped_oldest is set)
// or a pop (take the oldest entry of the lowest-numbered non-empty level, or
// return idle_code with popped_valid low when all levels are empty). Every
// item yields exactly one result. The result is registered: the item passes
// through an input register and then a result register. One item is accepted
// per cycle while the result is not stalled, as the single-port entry store
// does one write or one registered read per item. A stalled result holds the
// input register, which then stalls the input. Each level holds
// QUEUE_DEPTH-1 entries. Write idle_code only while no item is in flight.
module four_level_priority_ring_queue import prq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [1:0] i_level,
    input  logic [7:0] i_entry_code,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_popped_code,
    output logic       o_popped_valid,
    output logic [1:0] o_popped_level,
    output logic       o_dropped_oldest
);

    logic [7:0] r_idle_code;

    logic       r_in_valid;
    logic       r_action;
    t_level     r_level;
    logic [7:0] r_entry;

    logic       r_out_valid;
    logic       r_pop_valid;
    t_level     r_pop_level;
    logic       r_dropped;
    logic [7:0] r_alt_code;
    t_code      r_mem_q;

    t_code      r_store [SLOT_COUNT];

    logic       w_advance;
    logic       w_accept;
    t_sched     w_sched;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    prq_sched u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_action  (r_action),
        .i_level   (r_level),
        .o_sched   (w_sched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_code <= '0;
        end else if (i_cfg_we) begin
            r_idle_code <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_level  <= i_level;
            r_entry  <= i_entry_code;
        end
    end

    // entry store: one write or one read per item
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_sched.write) begin
                r_store[w_sched.addr] <= t_code'(r_entry);
            end else begin
                r_mem_q <= r_store[w_sched.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_pop_valid <= w_sched.hit;
            r_pop_level <= w_sched.lvl;
            r_dropped   <= w_sched.dropped;
            r_alt_code  <= w_sched.write ? 8'd0 : r_idle_code;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_popped_code    = r_pop_valid ? 8'(r_mem_q) : r_alt_code;
    assign o_popped_valid   = r_pop_valid;
    assign o_popped_level   = r_pop_level;
    assign o_dropped_oldest = r_dropped;

endmodule
